FILE: sv/srtf_pkg.sv
// Shared types and constants of the shortest-remaining-time-first scheduler.
// Depends on nothing; every other file of the block uses it by scoped names.
`timescale 1ns / 1ps

package srtf_pkg;

  // Field widths
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned BURST_W = 12;
  localparam int unsigned SLOT_W  = 5;

  // Default slot count
  localparam int unsigned MAX_PROCS_DEF = 32;

  // Time counter saturation value
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Action codes of an input transaction
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Best candidate held by the scan unit
  typedef struct packed {
    logic               found;
    logic [BURST_W-1:0] rt;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
  } scan_res_t;

endpackage

FILE: sv/srtf_if.sv
// Valid/ready channel interfaces of the scheduler: input items and results.
// Depends on srtf_pkg for the field widths.
`timescale 1ns / 1ps

interface srtf_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [srtf_pkg::TIME_W-1:0]  arrival;
  logic [srtf_pkg::BURST_W-1:0] burst;

  modport source (output valid, action, arrival, burst, input ready);
  modport sink   (input valid, action, arrival, burst, output ready);
  modport mon    (input valid, ready, action, arrival, burst);
endinterface

interface srtf_out_if;
  logic                        valid;
  logic                        ready;
  logic                        idle;
  logic [srtf_pkg::SLOT_W-1:0] running_slot;
  logic [srtf_pkg::TIME_W-1:0] tick_start;
  logic                        finished;
  logic [srtf_pkg::TIME_W-1:0] turnaround;
  logic [srtf_pkg::TIME_W-1:0] waiting;
  logic                        all_done;

  modport source (output valid, idle, running_slot, tick_start, finished, turnaround,
                  waiting, all_done, input ready);
  modport sink   (input valid, idle, running_slot, tick_start, finished, turnaround,
                  waiting, all_done, output ready);
  modport mon    (input valid, ready, idle, running_slot, tick_start, finished,
                  turnaround, waiting, all_done);
endinterface

FILE: sv/srtf_scan.sv
// Shared compare unit: keeps the eligible slot with the smallest remaining time.
// Depends on srtf_pkg; fed one slot per cycle by the sequencer in srtf_scheduler.
`timescale 1ns / 1ps

module srtf_scan #(
  parameter int unsigned IDX_W = 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clear_i,
  input  logic                         en_i,
  input  logic [IDX_W-1:0]             idx_i,
  input  logic [srtf_pkg::TIME_W-1:0]  arr_i,
  input  logic [srtf_pkg::BURST_W-1:0] bur_i,
  input  logic [srtf_pkg::BURST_W-1:0] rt_i,
  input  logic [srtf_pkg::TIME_W-1:0]  now_i,
  output srtf_pkg::scan_res_t          best_o,
  output logic [IDX_W-1:0]             best_idx_o
);

  srtf_pkg::scan_res_t best_q, best_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic                take;

  // Take an arrived, unfinished slot that beats the current best; ties keep the lower slot
  assign take = en_i && (arr_i <= now_i) && (rt_i != '0) &&
                (!best_q.found || (rt_i < best_q.rt));

  always_comb begin
    best_d = best_q;
    idx_d  = idx_q;
    if (clear_i) begin
      best_d.found = 1'b0;
    end else if (take) begin
      best_d.found   = 1'b1;
      best_d.rt      = rt_i;
      best_d.arrival = arr_i;
      best_d.burst   = bur_i;
      idx_d          = idx_i;
    end
  end

  // Clear the candidate under reset, otherwise advance it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
      idx_q  <= '0;
    end else begin
      best_q <= best_d;
      idx_q  <= idx_d;
    end
  end

  assign best_o     = best_q;
  assign best_idx_o = idx_q;

endmodule

FILE: sv/srtf_scheduler.sv
// Top level of the shortest-remaining-time-first scheduler: slot memory, sequencer,
// result register. Depends on srtf_pkg, srtf_if and srtf_scan.
`timescale 1ns / 1ps

// A load transaction writes arrival and burst time into the next free slot on
// acceptance and produces no result; loads beyond MAX_PROCS slots are dropped. A tick
// transaction scans the slot memory before it updates: the memory has a single read
// port and its entries pass one per cycle through one shared comparator, followed
// by a drain step and an update step that registers the result. The input side is
// ready only between ticks, so the next transaction is accepted only after the
// result is registered. The result waits in an output register, so the next
// transaction can be accepted while a result is still pending; a tick stalls in
// its update step until that register is free. Slot memory needs no clearing
// after reset.
module srtf_scheduler #(
  parameter int unsigned MAX_PROCS = srtf_pkg::MAX_PROCS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  srtf_in_if.sink    in_i,
  srtf_out_if.source out_o
);

  localparam int unsigned IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);
  localparam int unsigned TW    = srtf_pkg::TIME_W;
  localparam int unsigned BW    = srtf_pkg::BURST_W;
  localparam logic [CNT_W-1:0] SLOTS = CNT_W'(MAX_PROCS);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_UPDATE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0] loaded_q, loaded_d;
  logic [CNT_W-1:0] done_q, done_d;
  logic [TW-1:0]    time_q, time_d;
  logic [CNT_W-1:0] iss_q, iss_d;

  // Slot memory
  logic [TW-1:0] arr_mem [MAX_PROCS];
  logic [BW-1:0] bur_mem [MAX_PROCS];
  logic [BW-1:0] rt_mem  [MAX_PROCS];

  logic [TW-1:0]    rd_arr_q;
  logic [BW-1:0]    rd_bur_q;
  logic [BW-1:0]    rd_rt_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             rd_vld_q, rd_vld_d;

  logic in_fire, load_fire, tick_fire, load_wr, rd_en;
  logic rt_wr, commit, out_free;
  logic [IDX_W-1:0] rt_waddr;
  logic [BW-1:0]    rt_wdata;

  srtf_pkg::scan_res_t best;
  logic [IDX_W-1:0]    best_idx;
  logic [31:0]         slot_ext;

  logic [TW-1:0] next_time, tat, wt;
  logic          fin;

  // Result register
  logic                      out_vld_q;
  logic                      out_idle_q;
  logic [srtf_pkg::SLOT_W-1:0] out_slot_q;
  logic [TW-1:0]             out_start_q;
  logic                      out_fin_q;
  logic [TW-1:0]             out_tat_q;
  logic [TW-1:0]             out_wt_q;
  logic                      out_all_q;

  // Decode the input transaction
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign load_fire  = in_fire && (in_i.action == srtf_pkg::ACT_LOAD);
  assign tick_fire  = in_fire && (in_i.action == srtf_pkg::ACT_TICK);
  assign load_wr    = load_fire && (loaded_q < SLOTS);

  // Issue one slot read per scan cycle
  assign rd_en = (state_q == ST_SCAN) && (iss_q < loaded_q);

  // Completion bookkeeping of the chosen slot
  assign next_time = (time_q == srtf_pkg::TIME_MAX) ? time_q : time_q + 1'b1;
  assign fin       = best.found && (best.rt == BW'(1));
  assign tat       = next_time - best.arrival;
  assign wt        = (tat >= TW'(best.burst)) ? tat - TW'(best.burst) : '0;
  assign slot_ext  = 32'(best_idx);

  assign out_free = !out_vld_q || out_o.ready;
  assign commit   = (state_q == ST_UPDATE) && out_free;

  // Remaining-time write: the load or the decrement of the running slot
  assign rt_wr    = load_wr || (commit && best.found);
  assign rt_waddr = load_wr ? loaded_q[IDX_W-1:0] : best_idx;
  assign rt_wdata = load_wr ? in_i.burst : best.rt - 1'b1;

  // Sequencer
  always_comb begin
    state_d  = state_q;
    loaded_d = loaded_q;
    done_d   = done_q;
    time_d   = time_q;
    iss_d    = iss_q;
    rd_vld_d = rd_en;
    case (state_q)
      ST_IDLE: begin
        if (load_wr) begin
          loaded_d = loaded_q + 1'b1;
          if (in_i.burst == '0) begin
            done_d = done_q + 1'b1;
          end
        end
        if (tick_fire) begin
          iss_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          iss_d = iss_q + 1'b1;
        end else if (!rd_vld_q) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (commit) begin
          time_d = next_time;
          if (fin) begin
            done_d = done_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      loaded_q <= '0;
      done_q   <= '0;
      time_q   <= '0;
      iss_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      loaded_q <= loaded_d;
      done_q   <= done_d;
      time_q   <= time_d;
      iss_q    <= iss_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  // Slot memory: write on load or update, registered read during the scan
  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      arr_mem[loaded_q[IDX_W-1:0]] <= in_i.arrival;
      bur_mem[loaded_q[IDX_W-1:0]] <= in_i.burst;
    end
    if (rt_wr) begin
      rt_mem[rt_waddr] <= rt_wdata;
    end
    if (rd_en) begin
      rd_arr_q <= arr_mem[iss_q[IDX_W-1:0]];
      rd_bur_q <= bur_mem[iss_q[IDX_W-1:0]];
      rd_rt_q  <= rt_mem[iss_q[IDX_W-1:0]];
      rd_idx_q <= iss_q[IDX_W-1:0];
    end
  end

  srtf_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (tick_fire),
    .en_i       (rd_vld_q),
    .idx_i      (rd_idx_q),
    .arr_i      (rd_arr_q),
    .bur_i      (rd_bur_q),
    .rt_i       (rd_rt_q),
    .now_i      (time_q),
    .best_o     (best),
    .best_idx_o (best_idx)
  );

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (commit) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_idle_q  <= !best.found;
      out_slot_q  <= best.found ? slot_ext[srtf_pkg::SLOT_W-1:0] : '0;
      out_start_q <= time_q;
      out_fin_q   <= fin;
      out_tat_q   <= fin ? tat : '0;
      out_wt_q    <= fin ? wt : '0;
      out_all_q   <= (done_d == loaded_q);
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.idle         = out_idle_q;
  assign out_o.running_slot = out_slot_q;
  assign out_o.tick_start   = out_start_q;
  assign out_o.finished     = out_fin_q;
  assign out_o.turnaround   = out_tat_q;
  assign out_o.waiting      = out_wt_q;
  assign out_o.all_done     = out_all_q;

endmodule

FILE: sv/srtf_checker.sv
// Port-level checks of srtf_scheduler, bound to every instance of the top level.
// Depends on srtf_pkg; sees the channel signals of the top level's interface ports.
`timescale 1ns / 1ps

module srtf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        in_action_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        out_idle_i,
  input logic [srtf_pkg::SLOT_W-1:0] out_slot_i,
  input logic                        out_finished_i,
  input logic [srtf_pkg::TIME_W-1:0] out_turnaround_i,
  input logic [srtf_pkg::TIME_W-1:0] out_waiting_i
);

  // A pending result stays until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped before acceptance");

  // An idle tick reports slot zero and no completion
  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_idle_i) |-> (out_slot_i == '0 && !out_finished_i))
    else $error("idle tick reports a running slot");

  // Times are reported only for a finished slot
  a_times_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_finished_i) |-> (out_turnaround_i == '0 && out_waiting_i == '0))
    else $error("times reported without completion");

  // A tick occupies the block: no transaction in the following cycle
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_action_i == srtf_pkg::ACT_TICK)) |=> !in_ready_i)
    else $error("input ready right after a tick");

endmodule

bind srtf_scheduler srtf_checker u_srtf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_action_i      (in_i.action),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_idle_i       (out_o.idle),
  .out_slot_i       (out_o.running_slot),
  .out_finished_i   (out_o.finished),
  .out_turnaround_i (out_o.turnaround),
  .out_waiting_i    (out_o.waiting)
);

FILE: bench/srtf_scheduler_tb.sv
// Self-checking testbench of the shortest-remaining-time-first scheduler.
// Depends on srtf_pkg, srtf_if and srtf_scheduler; drives loads and ticks, predicts each report.
`timescale 1ns / 1ps

module srtf_scheduler_tb;

  localparam int unsigned CLK_PERIOD   = 12;
  localparam int unsigned NUM_SLOTS    = srtf_pkg::MAX_PROCS_DEF;
  localparam int unsigned RANDOM_ITEMS = 1450;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;

  // Handshake pressure applied while a command is on the bus
  typedef enum logic [1:0] {
    PACE_FREE,
    PACE_SEND_GAPS,
    PACE_RECV_STALLS,
    PACE_BOTH
  } pace_e;

  typedef struct {
    logic                         action;
    logic [srtf_pkg::TIME_W-1:0]  arrival;
    logic [srtf_pkg::BURST_W-1:0] burst;
    pace_e                        pace;
  } sched_cmd_t;

  typedef struct packed {
    logic                        idle;
    logic [srtf_pkg::SLOT_W-1:0] running_slot;
    logic [srtf_pkg::TIME_W-1:0] tick_start;
    logic                        finished;
    logic [srtf_pkg::TIME_W-1:0] turnaround;
    logic [srtf_pkg::TIME_W-1:0] waiting;
    logic                        all_done;
  } tick_report_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  srtf_in_if  in_bus ();
  srtf_out_if out_bus ();

  srtf_scheduler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  sched_cmd_t   sched_cmds[$];
  tick_report_t expected_reports[$];
  sched_cmd_t   cmd_on_bus;
  pace_e        pace_now = PACE_FREE;
  int unsigned  mismatch_count = 0;

  // Generation-side view of time and slot use, to aim arrivals
  int unsigned gen_clock  = 0;
  int unsigned gen_loaded = 0;

  // Predicted scheduler state
  logic [srtf_pkg::TIME_W-1:0]  proc_arrival [NUM_SLOTS];
  logic [srtf_pkg::BURST_W-1:0] proc_burst   [NUM_SLOTS];
  logic [srtf_pkg::BURST_W-1:0] proc_left    [NUM_SLOTS];
  int unsigned                  n_loaded  = 0;
  int unsigned                  n_done    = 0;
  logic [srtf_pkg::TIME_W-1:0]  clock_now = '0;

  // Load a slot, or scan for the shortest remaining job and run it for one unit
  task automatic apply_command(input sched_cmd_t c);
    tick_report_t                 r;
    int unsigned                  i;
    int unsigned                  best;
    logic                         found;
    logic [srtf_pkg::BURST_W-1:0] best_left;
    logic [srtf_pkg::TIME_W-1:0]  tat;
    logic [srtf_pkg::TIME_W-1:0]  bur_ext;
    if (c.action == srtf_pkg::ACT_LOAD) begin
      if (n_loaded < NUM_SLOTS) begin
        proc_arrival[n_loaded] = c.arrival;
        proc_burst[n_loaded]   = c.burst;
        proc_left[n_loaded]    = c.burst;
        if (c.burst == '0) n_done++;
        n_loaded++;
      end
    end else begin
      found     = 1'b0;
      best      = 0;
      best_left = '0;
      for (i = 0; i < n_loaded; i++) begin
        if (proc_arrival[i] <= clock_now && proc_left[i] != '0 &&
            (!found || proc_left[i] < best_left)) begin
          found     = 1'b1;
          best_left = proc_left[i];
          best      = i;
        end
      end
      r            = '0;
      r.idle       = !found;
      r.tick_start = clock_now;
      if (clock_now != srtf_pkg::TIME_MAX) clock_now++;
      if (found) begin
        r.running_slot  = srtf_pkg::SLOT_W'(best);
        proc_left[best] = best_left - 1'b1;
        if (best_left == srtf_pkg::BURST_W'(1)) begin
          n_done++;
          tat          = clock_now - proc_arrival[best];
          bur_ext      = srtf_pkg::TIME_W'(proc_burst[best]);
          r.finished   = 1'b1;
          r.turnaround = tat;
          r.waiting    = (tat >= bur_ext) ? tat - bur_ext : '0;
        end
      end
      r.all_done = (n_done == n_loaded);
      expected_reports.push_back(r);
    end
  endtask

  // Compare the report on the output bus with the oldest prediction
  task automatic check_report();
    tick_report_t got;
    tick_report_t want;
    got.idle         = out_bus.idle;
    got.running_slot = out_bus.running_slot;
    got.tick_start   = out_bus.tick_start;
    got.finished     = out_bus.finished;
    got.turnaround   = out_bus.turnaround;
    got.waiting      = out_bus.waiting;
    got.all_done     = out_bus.all_done;
    if (expected_reports.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: report with none pending: idle=%0d slot=%0d start=%0d", $time,
                 got.idle, got.running_slot, got.tick_start);
    end else begin
      want = expected_reports.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: expected idle=%0d slot=%0d start=%0d fin=%0d tat=%0d wait=%0d done=%0d",
                   $time, want.idle, want.running_slot, want.tick_start, want.finished,
                   want.turnaround, want.waiting, want.all_done);
          $display("%0t: actual   idle=%0d slot=%0d start=%0d fin=%0d tat=%0d wait=%0d done=%0d",
                   $time, got.idle, got.running_slot, got.tick_start, got.finished,
                   got.turnaround, got.waiting, got.all_done);
        end
      end
    end
  endtask

  function automatic logic sender_gap(input pace_e pace);
    case (pace)
      PACE_SEND_GAPS: return $urandom_range(0, 99) < 79;
      PACE_BOTH:      return $urandom_range(0, 99) < 16;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stall(input pace_e pace);
    case (pace)
      PACE_RECV_STALLS: return $urandom_range(0, 99) < 79;
      PACE_BOTH:        return $urandom_range(0, 99) < 16;
      default:          return 1'b0;
    endcase
  endfunction

  task automatic queue_load(input int unsigned arr, input int unsigned bur, input pace_e pace);
    sched_cmd_t c;
    c.action  = srtf_pkg::ACT_LOAD;
    c.arrival = srtf_pkg::TIME_W'(arr);
    c.burst   = srtf_pkg::BURST_W'(bur);
    c.pace    = pace;
    sched_cmds.push_back(c);
    if (gen_loaded < NUM_SLOTS) gen_loaded++;
  endtask

  // Tick commands carry random don't-care fields
  task automatic queue_tick(input pace_e pace);
    sched_cmd_t c;
    c.action  = srtf_pkg::ACT_TICK;
    c.arrival = srtf_pkg::TIME_W'($urandom);
    c.burst   = srtf_pkg::BURST_W'($urandom);
    c.pace    = pace;
    sched_cmds.push_back(c);
    if (gen_clock < srtf_pkg::TIME_MAX) gen_clock++;
  endtask

  // Mostly near the current time, some already past, some far ahead
  function automatic int unsigned pick_arrival();
    int unsigned sel;
    int unsigned a;
    sel = $urandom_range(0, 9);
    if (sel <= 5) a = gen_clock + $urandom_range(0, 30);
    else if (sel <= 7) a = (gen_clock > 200) ? gen_clock - $urandom_range(0, 200)
                                             : $urandom_range(0, gen_clock);
    else if (sel == 8) a = $urandom_range(0, 65535);
    else a = gen_clock + $urandom_range(0, 1500);
    return (a > srtf_pkg::TIME_MAX) ? srtf_pkg::TIME_MAX : a;
  endfunction

  // Mostly short jobs so that completions are frequent
  function automatic int unsigned pick_burst();
    int unsigned sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return 0;
    if (sel == 1) return $urandom_range(0, 4095);
    return $urandom_range(1, 12);
  endfunction

  // Driver: present the next command, predict on each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid   <= 1'b0;
      in_bus.action  <= srtf_pkg::ACT_LOAD;
      in_bus.arrival <= '0;
      in_bus.burst   <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) apply_command(cmd_on_bus);
      if (!in_bus.valid || in_bus.ready) begin
        if (sched_cmds.size() != 0 && !sender_gap(sched_cmds[0].pace)) begin
          cmd_on_bus = sched_cmds.pop_front();
          pace_now       <= cmd_on_bus.pace;
          in_bus.valid   <= 1'b1;
          in_bus.action  <= cmd_on_bus.action;
          in_bus.arrival <= cmd_on_bus.arrival;
          in_bus.burst   <= cmd_on_bus.burst;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted report, throttle ready per pacing
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) check_report();
      out_bus.ready <= !receiver_stall(pace_now);
    end
  end

  initial begin
    int unsigned k;
    pace_e       pace;
    rst_ni = 1'b0;

    // Empty store: idle ticks report everything done
    queue_tick(PACE_FREE);
    queue_tick(PACE_FREE);
    // Zero burst counts as done at once
    queue_load(0, 0, PACE_FREE);
    queue_tick(PACE_FREE);
    // Tie between two equal jobs goes to the lower slot; short late job runs ahead of an earlier, longer one
    queue_load(0, 2, PACE_FREE);
    queue_load(4, 1, PACE_FREE);
    queue_load(0, 2, PACE_FREE);
    repeat (7) queue_tick(PACE_FREE);
    // Job not yet arrived leaves the tick idle
    queue_load(12, 3, PACE_FREE);
    queue_tick(PACE_FREE);
    // Longest burst, later preempted by the shorter arrival
    queue_load(0, 4095, PACE_FREE);
    queue_tick(PACE_FREE);
    queue_tick(PACE_FREE);

    // Random loads spread among ticks, one pacing style per quarter
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      pace = pace_e'((k * 4) / RANDOM_ITEMS);
      if (gen_loaded < NUM_SLOTS - 3 && $urandom_range(0, 49) == 0)
        queue_load(pick_arrival(), pick_burst(), pace);
      else
        queue_tick(pace);
    end

    // Fill the store, then overflow it
    while (gen_loaded < NUM_SLOTS - 3) queue_load(pick_arrival(), pick_burst(), PACE_FREE);
    queue_load(gen_clock, 40, PACE_FREE);
    queue_load(65535, 4095, PACE_FREE);
    queue_load(0, 1, PACE_FREE);
    repeat (3) queue_load($urandom_range(0, 65535), $urandom_range(0, 4095), PACE_FREE);
    repeat (60) queue_tick(PACE_FREE);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every command accepted and every report seen
    while (sched_cmds.size() != 0 || in_bus.valid || expected_reports.size() != 0)
      @(negedge clk_i);
    repeat (100) @(negedge clk_i);

    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: files.f
sv/srtf_pkg.sv
sv/srtf_if.sv
sv/srtf_scan.sv
sv/srtf_scheduler.sv
sv/srtf_checker.sv
bench/srtf_scheduler_tb.sv
